FILE: rtl/iir6_pkg.sv
// Shared types, constants and a helper function of the sixth-order IIR bandpass filter.
// Depends on nothing; every other file of the block imports it.
package iir6_pkg;

    localparam int COEF_W           = 32;
    localparam int DELAY_W          = 56;
    localparam int SUM_W            = 58;
    localparam int NUM_TAPS         = 6;
    localparam int NUM_REGS         = 7;
    localparam int REG_IDX_W        = 3;
    localparam int TAP_IDX_W        = 3;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 24;

    localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(NUM_TAPS - 1);

    localparam logic signed [COEF_W-1:0] REG_RESET [NUM_REGS] = '{
        32'sd474987, -32'sd75518173, 32'sd142053889, -32'sd144301180,
        32'sd84213230, -32'sd26809474, 32'sd3584501
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GX,
        ST_OUTPUT,
        ST_MUL_AY,
        ST_UPDATE,
        ST_DELIVER
    } iir6_state_t;

    // Numerator pattern 0,-3,0,3,0,-1 applied to g*x for taps b1 to b6.
    function automatic logic signed [SUM_W-1:0] num_term(
        input logic [TAP_IDX_W-1:0] tap,
        input logic signed [SUM_W-1:0] gx
    );
        logic signed [SUM_W-1:0] gx3;
        gx3 = (gx <<< 1) + gx;
        case (tap)
            3'd1:    num_term = -gx3;
            3'd3:    num_term = gx3;
            3'd5:    num_term = -gx;
            default: num_term = '0;
        endcase
    endfunction

endpackage

FILE: rtl/iir6_sermul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
// Depends on iir6_pkg for the coefficient width.
module iir6_sermul
    import iir6_pkg::*;
#(
    parameter int MW = SAMPLE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [COEF_W-1:0]    mcand,
    input  logic signed [MW-1:0]        mplier,
    output logic                        done,
    output logic signed [COEF_W+MW-1:0] product
);

    localparam int P   = COEF_W + MW;
    localparam int CW  = $clog2(MW);

    logic signed [P-1:0] acc_reg, acc_next;
    logic signed [P-1:0] mc_reg;
    logic [MW-1:0]       mp_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                last_bit;

    assign last_bit = (cnt_reg == CW'(MW - 1));

    always_comb begin
        acc_next = acc_reg;
        if (mp_reg[0]) begin
            if (last_bit) begin
                acc_next = acc_reg - mc_reg;
            end else begin
                acc_next = acc_reg + mc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            mc_reg  <= P'(mcand);
            mp_reg  <= mplier;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            mc_reg  <= mc_reg <<< 1;
            mp_reg  <= mp_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/iir_bandpass_filter_order6.sv
// Top level of the sixth-order IIR bandpass filter, transposed direct form II.
// Depends on iir6_pkg and iir6_sermul.
//
// Each item uses the single bit-serial multiplier, which forms g*x and then a1*y to
// a6*y, one multiplier bit per cycle, with a start and a done strobe for each product,
// and each delay entry is updated in the cycle after its product. A new item is taken
// once the previous result has moved into the output register, which holds it until
// the consumer takes it. Coefficient writes take effect at once.
module iir_bandpass_filter_order6
    import iir6_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [REG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    output logic                          m_saturated
);

    localparam int P = COEF_W + SAMPLE_WIDTH;
    localparam logic signed [SUM_W-1:0] YMAX_W  = (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] YMIN_W  = -YMAX_W - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] DMAX_W  = (SUM_W'(1) <<< (DELAY_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] DMIN_W  = -DMAX_W - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ROUND_W = SUM_W'(1) <<< (FRAC_BITS - 1);

    iir6_state_t state_reg, state_next;

    logic signed [COEF_W-1:0]       coef_reg [NUM_REGS];
    logic signed [DELAY_W-1:0]      dl_reg [NUM_TAPS];
    logic [TAP_IDX_W-1:0]           tap_reg;
    logic signed [SUM_W-1:0]        gx_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           sat_reg;
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_reg;
    logic                           m_sat_reg;

    logic                           mul_start;
    logic                           mul_done;
    logic signed [COEF_W-1:0]       mul_mcand;
    logic signed [SAMPLE_WIDTH-1:0] mul_mplier;
    logic signed [P-1:0]            mul_product;

    logic signed [SUM_W-1:0]        acc_sum;
    logic signed [SUM_W-1:0]        y_wide;
    logic signed [SAMPLE_WIDTH-1:0] y_clamped;
    logic                           y_sat;
    logic signed [SUM_W-1:0]        next_delay;
    logic signed [SUM_W-1:0]        upd_sum;
    logic signed [DELAY_W-1:0]      upd_clamped;
    logic                           out_free;

    iir6_sermul #(
        .MW(SAMPLE_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        acc_sum = SUM_W'(mul_product) + SUM_W'(dl_reg[0]) + ROUND_W;
        y_wide  = acc_sum >>> FRAC_BITS;
        y_sat   = 1'b0;
        if (y_wide > YMAX_W) begin
            y_clamped = YMAX_W[SAMPLE_WIDTH-1:0];
            y_sat     = 1'b1;
        end else if (y_wide < YMIN_W) begin
            y_clamped = YMIN_W[SAMPLE_WIDTH-1:0];
            y_sat     = 1'b1;
        end else begin
            y_clamped = y_wide[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        if (tap_reg == LAST_TAP) begin
            next_delay = '0;
        end else begin
            next_delay = SUM_W'(dl_reg[TAP_IDX_W'(tap_reg + TAP_IDX_W'(1))]);
        end
        upd_sum = next_delay + num_term(tap_reg, gx_reg) - SUM_W'(mul_product);
        if (upd_sum > DMAX_W) begin
            upd_clamped = DMAX_W[DELAY_W-1:0];
        end else if (upd_sum < DMIN_W) begin
            upd_clamped = DMIN_W[DELAY_W-1:0];
        end else begin
            upd_clamped = upd_sum[DELAY_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL_GX;
                end
            end
            ST_MUL_GX: begin
                if (mul_done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: state_next = ST_MUL_AY;
            ST_MUL_AY: begin
                if (mul_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (tap_reg == LAST_TAP) begin
                    state_next = ST_DELIVER;
                end else begin
                    state_next = ST_MUL_AY;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        mul_start  = 1'b0;
        mul_mcand  = coef_reg[0];
        mul_mplier = s_sample_in;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                mul_start = s_valid;
            end
            ST_OUTPUT: begin
                mul_start  = 1'b1;
                mul_mcand  = coef_reg[1];
                mul_mplier = y_clamped;
            end
            ST_UPDATE: begin
                mul_start  = (tap_reg != LAST_TAP);
                mul_mplier = y_reg;
                case (tap_reg)
                    3'd0:    mul_mcand = coef_reg[2];
                    3'd1:    mul_mcand = coef_reg[3];
                    3'd2:    mul_mcand = coef_reg[4];
                    3'd3:    mul_mcand = coef_reg[5];
                    3'd4:    mul_mcand = coef_reg[6];
                    default: mul_mcand = coef_reg[0];
                endcase
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                coef_reg[i] <= REG_RESET[i];
            end
            for (int i = 0; i < NUM_TAPS; i++) begin
                dl_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
                coef_reg[cfg_index] <= cfg_wdata;
            end
            if (state_reg == ST_OUTPUT) begin
                tap_reg <= '0;
            end
            if (state_reg == ST_UPDATE) begin
                dl_reg[tap_reg] <= upd_clamped;
                tap_reg         <= tap_reg + TAP_IDX_W'(1);
            end
            if (state_reg == ST_DELIVER && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUTPUT) begin
            gx_reg  <= SUM_W'(mul_product);
            y_reg   <= y_clamped;
            sat_reg <= y_sat;
        end
        if (state_reg == ST_DELIVER && out_free) begin
            m_sample_reg <= y_reg;
            m_sat_reg    <= sat_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_saturated  = m_sat_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second item was accepted while one was in flight.");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_sample_out == YMAX_W[SAMPLE_WIDTH-1:0] ||
             m_sample_out == YMIN_W[SAMPLE_WIDTH-1:0]))
        else $error("Saturation flag set on a sample that is not a range limit.");

    a_mul_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_GX || state_reg == ST_MUL_AY))
        else $error("Multiplier finished outside a multiply phase.");

endmodule

FILE: verif/tb_iir_bandpass_filter_order6.sv
// Self-checking testbench for the sixth-order IIR bandpass filter.
// A directed table, then random items, over several coefficient settings, checked
// against a fixed-point predictor. Depends on iir6_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_iir_bandpass_filter_order6;
    import iir6_pkg::*;

    localparam int SW         = SAMPLE_WIDTH_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int SETTLE     = 200;
    localparam int LONG_HOLD  = 800;
    localparam int RAND_ITEMS = 110;

    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_POLE1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_POLE2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POLE3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_POLE4  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POLE5  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POLE6  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7fff_ffff;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
    localparam logic [COEF_W-1:0] HALF_ONE = 32'h0080_0000;

    localparam longint DELAY_HI = (64'sd1 <<< (DELAY_W - 1)) - 1;
    localparam longint DELAY_LO = -DELAY_HI - 1;
    localparam longint NUM_PATTERN [NUM_TAPS] = '{0, -3, 0, 3, 0, -1};

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [REG_IDX_W-1:0]    idx;
        logic [COEF_W-1:0]       wdata;
        logic signed [SW-1:0]    sample;
        bit                      typed;
        logic signed [SW-1:0]    y_typed;
        logic                    sat_typed;
    } stim_row_t;

    typedef struct {
        logic signed [SW-1:0] y;
        logic                 sat;
    } filt_out_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]   cfg_index = '0;
    logic [COEF_W-1:0]      cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [SW-1:0]   s_sample_in = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [SW-1:0]   m_sample_out;
    logic                   m_saturated;

    longint    coef [NUM_REGS];
    longint    delay [NUM_TAPS];
    filt_out_t expected_out [$];
    int        errors = 0;
    int        cycles = 0;
    int        items_sent = 0;
    int        outputs_seen = 0;
    int        sat_seen = 0;
    bit        burst = 1'b0;
    bit        hold_req = 1'b0;

    iir_bandpass_filter_order6 uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample_out(m_sample_out), .m_saturated(m_saturated)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint clamp_delay(input longint v);
        if (v > DELAY_HI) return DELAY_HI;
        if (v < DELAY_LO) return DELAY_LO;
        return v;
    endfunction

    function automatic filt_out_t filter_sample(input logic signed [SW-1:0] sample);
        longint    x, gx, acc, y, nxt;
        filt_out_t r;
        x = sample;
        gx = coef[0] * x;
        acc = gx + delay[0];
        y = (acc + (64'sd1 <<< (FB - 1))) >>> FB;
        r.sat = 1'b0;
        if (y > 32767) begin
            y = 32767;
            r.sat = 1'b1;
        end
        if (y < -32768) begin
            y = -32768;
            r.sat = 1'b1;
        end
        for (int i = 0; i < NUM_TAPS; i++) begin
            nxt = (i + 1 < NUM_TAPS) ? delay[i + 1] : 64'sd0;
            delay[i] = clamp_delay(nxt + NUM_PATTERN[i] * gx - coef[i + 1] * y);
        end
        r.y = y[SW-1:0];
        return r;
    endfunction

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx < NUM_REGS)
            coef[idx] = longint'(signed'(val));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_sample(input stim_row_t row);
        int        gap;
        filt_out_t r;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= row.sample;
        do @(posedge aclk); while (!s_ready);
        r = filter_sample(row.sample);
        if (row.typed) begin
            r.y = row.y_typed;
            r.sat = row.sat_typed;
        end
        expected_out.push_back(r);
        items_sent++;
    endtask

    task automatic set_coefs(input logic [COEF_W-1:0] g, input logic [COEF_W-1:0] p [NUM_TAPS]);
        drain_outputs();
        write_coef(REG_GAIN, g);
        for (int i = 0; i < NUM_TAPS; i++)
            write_coef(REG_IDX_W'(i + 1), p[i]);
    endtask

    function automatic stim_row_t wr(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
        stim_row_t r;
        r = '{ROW_WRITE, idx, v, '0, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t smp(input logic signed [SW-1:0] x);
        stim_row_t r;
        r = '{ROW_SAMPLE, '0, '0, x, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t smp_typed(input logic signed [SW-1:0] x,
                                            input logic signed [SW-1:0] y, input logic sat);
        stim_row_t r;
        r = '{ROW_SAMPLE, '0, '0, x, 1'b1, y, sat};
        return r;
    endfunction

    // Receiver: random stalls, bursts with none, and one long hold-off on request.
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!burst) begin
                stall = $urandom_range(0, 12);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        filt_out_t e;
        if (aresetn && m_valid && m_ready) begin
            outputs_seen++;
            if (m_saturated)
                sat_seen++;
            if (expected_out.size() == 0) begin
                $error("unexpected item: sample_out %0d saturated %0b", m_sample_out, m_saturated);
                errors++;
            end else begin
                e = expected_out.pop_front();
                if (m_sample_out !== e.y) begin
                    $error("sample_out: expected %0d, actual %0d", e.y, m_sample_out);
                    errors++;
                end
                if (m_saturated !== e.sat) begin
                    $error("saturated: expected %0b, actual %0b", e.sat, m_saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t         directed [$];
        stim_row_t         row;
        logic [COEF_W-1:0] poles [NUM_TAPS];
        logic [COEF_W-1:0] gain;

        for (int i = 0; i < NUM_REGS; i++)
            coef[i] = longint'(REG_RESET[i]);
        for (int i = 0; i < NUM_TAPS; i++)
            delay[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset coefficients: silence, a tiny step, then full-scale extremes.
        directed = '{smp_typed(16'sd0, 16'sd0, 1'b0), smp_typed(16'sd1, 16'sd0, 1'b0),
                     smp(16'sd32767), smp(-16'sd32768), smp(16'sd32767), smp(-16'sd32768),
                     smp(16'sd0), smp(16'sd0),
                     // Half gain and no feedback give rounding ties; index 7 is ignored.
                     wr(REG_GAIN, HALF_ONE), wr(REG_POLE1, '0), wr(REG_POLE2, '0),
                     wr(REG_POLE3, '0), wr(REG_POLE4, '0), wr(REG_POLE5, '0),
                     wr(REG_POLE6, '0), wr(REG_UNUSED, COEF_MAX),
                     smp(16'sd1), smp(-16'sd1), smp(16'sd3), smp(-16'sd3),
                     // Extreme coefficients drive output clipping.
                     wr(REG_GAIN, COEF_MAX), wr(REG_POLE1, COEF_MIN), wr(REG_POLE6, COEF_MAX),
                     smp(16'sd32767), smp(-16'sd32768), smp(16'sd32767), smp(16'sd0)};
        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_WRITE) begin
                drain_outputs();
                write_coef(row.idx, row.wdata);
            end else begin
                send_sample(row);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    gain = REG_RESET[0];
                    for (int i = 0; i < NUM_TAPS; i++) poles[i] = REG_RESET[i + 1];
                end
                1, 3: begin
                    gain = $urandom();
                    for (int i = 0; i < NUM_TAPS; i++)
                        poles[i] = $urandom() >>> $urandom_range(0, 8);
                end
                2: begin
                    gain = COEF_MIN;
                    for (int i = 0; i < NUM_TAPS; i++) poles[i] = (i % 2) ? COEF_MAX : COEF_MIN;
                end
                default: begin
                    gain = $urandom_range(1, 4) << 22;
                    for (int i = 0; i < NUM_TAPS; i++) poles[i] = REG_RESET[i + 1];
                end
            endcase
            set_coefs(gain, poles);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (n % 30 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (ph == 1 && n == 40)
                    hold_req = 1'b1;
                if (ph == 3 && n == 50) begin
                    burst = 1'b0;
                    s_valid <= 1'b0;
                    while (expected_out.size() != 0)
                        @(posedge aclk);
                end
                case ($urandom_range(0, 9))
                    0:       row = smp(16'sd32767);
                    1:       row = smp(-16'sd32768);
                    2:       row = smp(SW'($urandom_range(0, 255) - 128));
                    default: row = smp(SW'($urandom()));
                endcase
                send_sample(row);
            end
        end

        burst = 1'b0;
        drain_outputs();
        $display("Sent %0d samples over %0d coefficient settings; %0d outputs, %0d clipped.",
                 items_sent, 8, outputs_seen, sat_seen);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
rtl/iir6_pkg.sv
rtl/iir6_sermul.sv
rtl/iir_bandpass_filter_order6.sv
verif/tb_iir_bandpass_filter_order6.sv
